/* rtl/core/fragment_peak_matcher_macros.svh */
// Assertion helpers shared by the matcher core.
`ifndef FRAGMENT_PEAK_MATCHER_MACROS_SVH
`define FRAGMENT_PEAK_MATCHER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define FPM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("fragment_peak_matcher: assertion failed");

// Next-cycle implication, checked outside reset.
`define FPM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("fragment_peak_matcher: assertion failed");

`endif

/* rtl/core/fpm_pkg.sv */
`default_nettype none
package fpm_pkg;

	localparam int unsigned DEPTH_DEFAULT = 1024;
	localparam int unsigned FRAC_DEFAULT  = 16;
	localparam int unsigned RANK_DEFAULT  = 16;

	localparam int unsigned MZ_W    = 32;
	localparam int unsigned TOL_W   = 16;
	localparam int unsigned PRANK_W = 16;
	localparam int unsigned IDX_W   = 10;
	localparam int unsigned MCNT_W  = 11;

	localparam logic [TOL_W-1:0] TOL_RESET = 16'd1311;

	// Request types
	localparam logic [1:0] REQ_LOAD = 2'd0;
	localparam logic [1:0] REQ_PEAK = 2'd1;
	localparam logic [1:0] REQ_READ = 2'd2;

	// Result status codes
	localparam logic [1:0] STS_OK     = 2'd0;
	localparam logic [1:0] STS_FULL   = 2'd1;
	localparam logic [1:0] STS_NO_IDX = 2'd2;

	// Result register update codes
	localparam logic [2:0] RES_HOLD   = 3'd0;
	localparam logic [2:0] RES_LOAD   = 3'd1;
	localparam logic [2:0] RES_PEAK   = 3'd2;
	localparam logic [2:0] RES_RD_OK  = 3'd3;
	localparam logic [2:0] RES_RD_BAD = 3'd4;
	localparam logic [2:0] RES_ZERO   = 3'd5;

	typedef struct packed {
		logic [1:0]         req_type;
		logic               start_new;
		logic [MZ_W-1:0]    value_mz;
		logic [PRANK_W-1:0] peak_rank;
		logic [IDX_W-1:0]   entry_index;
	} fpm_in_t;

	typedef struct packed {
		logic [1:0]         status;
		logic [MCNT_W-1:0]  match_count;
		logic               entry_valid;
		logic [MZ_W-1:0]    entry_fragment_mz;
		logic [MZ_W-1:0]    entry_peak_mz;
		logic [PRANK_W-1:0] entry_rank;
	} fpm_out_t;

	typedef struct packed {
		logic       capture;
		logic       load;
		logic       srch_init;
		logic       srch_issue;
		logic       srch_cmp;
		logic       scan_init;
		logic       scan_issue;
		logic       scan_eval;
		logic       rd_issue;
		logic       out_load;
		logic [2:0] res_op;
	} fpm_cmd_t;

	typedef struct packed {
		logic lo_lt_hi;
		logic idx_lt_cnt;
		logic scan_stop;
		logic rd_in_range;
	} fpm_sts_t;

endpackage
`default_nettype wire

/* rtl/core/fpm_datapath.sv */
`default_nettype none
module fpm_datapath
	import fpm_pkg::*;
#(
	parameter int unsigned TABLE_DEPTH = DEPTH_DEFAULT,
	parameter int unsigned FRAC_BITS   = FRAC_DEFAULT,
	parameter int unsigned RANK_BITS   = RANK_DEFAULT
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire fpm_in_t          in_data,
	input  wire logic             cfg_we,
	input  wire logic [TOL_W-1:0] cfg_wdata,
	input  wire fpm_cmd_t         cmd,
	output fpm_sts_t              sts,
	output fpm_out_t              out_data
);

	localparam int unsigned AW = $clog2(TABLE_DEPTH);
	localparam int unsigned CW = AW + 1;
	localparam int unsigned RW = 1 + MZ_W + RANK_BITS;
	localparam logic [MZ_W-1:0] HALF  = MZ_W'(1) << (FRAC_BITS - 1);
	localparam logic [CW-1:0]   DEPTH = CW'(TABLE_DEPTH);

	fpm_in_t            item_q;
	fpm_out_t           res_q;
	fpm_out_t           out_q;
	logic [TOL_W-1:0]   tol_q;
	logic [CW-1:0]      count_q;
	logic [CW-1:0]      match_cnt_q;
	logic [CW-1:0]      lo_q;
	logic [CW-1:0]      hi_q;
	logic [CW-1:0]      idx_q;

	logic [MZ_W-1:0]    frag_mem [TABLE_DEPTH];
	logic [RW-1:0]      rec_mem  [TABLE_DEPTH];
	logic [MZ_W-1:0]    frag_rd_q;
	logic [RW-1:0]      rec_rd_q;

	logic [RANK_BITS-1:0] rank_in;
	logic [CW-1:0]      mid;
	logic [CW-1:0]      eff_cnt;
	logic               full;
	logic [MZ_W-1:0]    thr;
	logic [MZ_W-1:0]    mz_gap;
	logic               in_tol;
	logic               better;
	logic               rec_match;
	logic [MZ_W:0]      upper;
	logic [AW-1:0]      rd_addr;
	logic               frag_we;
	logic               rec_we;
	logic [AW-1:0]      wr_addr;
	logic [RW-1:0]      rec_wdata;
	logic               rd_mark;
	logic [MZ_W-1:0]    rd_peak;
	logic [RANK_BITS-1:0] rd_rank;

	assign rank_in = RANK_BITS'(32'(item_q.peak_rank));
	assign mid     = lo_q + ((hi_q - lo_q) >> 1);
	assign eff_cnt = item_q.start_new ? '0 : count_q;
	assign full    = (eff_cnt >= DEPTH);
	assign thr     = (item_q.value_mz >= HALF) ? (item_q.value_mz - HALF) : '0;

	assign rd_mark = rec_rd_q[RW-1];
	assign rd_peak = rec_rd_q[RW-2 -: MZ_W];
	assign rd_rank = rec_rd_q[RANK_BITS-1:0];

	// Window test on the entry fetched last cycle
	assign mz_gap = (frag_rd_q > item_q.value_mz) ? (frag_rd_q - item_q.value_mz)
	                                              : (item_q.value_mz - frag_rd_q);
	assign in_tol = (mz_gap < MZ_W'(tol_q));
	assign upper  = {1'b0, item_q.value_mz} + (MZ_W + 1)'(tol_q);
	assign better = !rd_mark || (rd_rank > rank_in);
	assign rec_match = cmd.scan_eval && in_tol && better;

	assign sts.lo_lt_hi    = (lo_q < hi_q);
	assign sts.idx_lt_cnt  = (idx_q < count_q);
	assign sts.scan_stop   = !in_tol && ({1'b0, frag_rd_q} > upper);
	assign sts.rd_in_range = (32'(item_q.entry_index) < 32'(count_q));

	always_comb begin
		if (cmd.srch_issue) begin
			rd_addr = mid[AW-1:0];
		end else if (cmd.rd_issue) begin
			rd_addr = AW'(item_q.entry_index);
		end else if (cmd.scan_issue) begin
			rd_addr = idx_q[AW-1:0];
		end else begin
			rd_addr = '0;
		end
	end

	always_comb begin
		frag_we   = 1'b0;
		rec_we    = 1'b0;
		wr_addr   = idx_q[AW-1:0];
		rec_wdata = {1'b1, item_q.value_mz, rank_in};
		if (cmd.load && !full) begin
			frag_we   = 1'b1;
			rec_we    = 1'b1;
			wr_addr   = eff_cnt[AW-1:0];
			rec_wdata = '0;
		end else if (rec_match) begin
			rec_we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (frag_we) begin
			frag_mem[wr_addr] <= item_q.value_mz;
		end
		frag_rd_q <= frag_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (rec_we) begin
			rec_mem[wr_addr] <= rec_wdata;
		end
		rec_rd_q <= rec_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q       <= TOL_RESET;
			count_q     <= '0;
			match_cnt_q <= '0;
		end else begin
			if (cfg_we) begin
				tol_q <= cfg_wdata;
			end
			if (cmd.load) begin
				count_q <= full ? eff_cnt : eff_cnt + CW'(1);
			end
			if (cmd.srch_init) begin
				match_cnt_q <= '0;
			end else if (rec_match) begin
				match_cnt_q <= match_cnt_q + CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			item_q <= in_data;
		end
		if (cmd.srch_init) begin
			lo_q <= '0;
			hi_q <= count_q;
		end else if (cmd.srch_cmp) begin
			if (frag_rd_q < thr) begin
				lo_q <= mid + CW'(1);
			end else begin
				hi_q <= mid;
			end
		end
		if (cmd.scan_init) begin
			idx_q <= lo_q;
		end else if (cmd.scan_eval) begin
			idx_q <= idx_q + CW'(1);
		end
		if (cmd.out_load) begin
			out_q <= res_q;
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.res_op)
			RES_HOLD: begin
				res_q <= res_q;
			end
			RES_LOAD: begin
				res_q        <= '0;
				res_q.status <= full ? STS_FULL : STS_OK;
			end
			RES_PEAK: begin
				res_q             <= '0;
				res_q.match_count <= MCNT_W'(match_cnt_q);
			end
			RES_RD_OK: begin
				res_q                   <= '0;
				res_q.entry_fragment_mz <= frag_rd_q;
				res_q.entry_valid       <= rd_mark;
				res_q.entry_peak_mz     <= rd_mark ? rd_peak : '0;
				res_q.entry_rank        <= rd_mark ? PRANK_W'(rd_rank) : '0;
			end
			RES_RD_BAD: begin
				res_q        <= '0;
				res_q.status <= STS_NO_IDX;
			end
			default: begin
				res_q <= '0;
			end
		endcase
	end

	assign out_data = out_q;

`include "fragment_peak_matcher_macros.svh"

	`FPM_ASSERT_NOW(a_count_bound, clk, arst_n, 1'b1, count_q <= DEPTH)
	`FPM_ASSERT_NOW(a_rec_write_loaded, clk, arst_n, rec_match, idx_q < count_q)

endmodule
`default_nettype wire

/* rtl/core/fpm_ctrl.sv */
`default_nettype none
module fpm_ctrl
	import fpm_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	input  wire logic [1:0] req_type,
	output logic            in_stall,
	output logic            out_valid,
	input  wire logic       out_stall,
	input  wire fpm_sts_t   sts,
	output fpm_cmd_t        cmd
);

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_LOAD  = 4'd1;
	localparam logic [3:0] ST_SINIT = 4'd2;
	localparam logic [3:0] ST_SCHK  = 4'd3;
	localparam logic [3:0] ST_SCMP  = 4'd4;
	localparam logic [3:0] ST_CHK   = 4'd5;
	localparam logic [3:0] ST_EVAL  = 4'd6;
	localparam logic [3:0] ST_RADDR = 4'd7;
	localparam logic [3:0] ST_RDATA = 4'd8;
	localparam logic [3:0] ST_DONE  = 4'd9;

	logic [3:0] state_q;
	logic [3:0] state_d;
	logic       out_valid_q;
	logic       accept;
	logic       can_push;

	assign in_stall  = (state_q != ST_IDLE);
	assign accept    = in_valid && !in_stall;
	assign can_push  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		cmd.res_op = RES_HOLD;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					cmd.capture = 1'b1;
					case (req_type)
						REQ_LOAD: state_d = ST_LOAD;
						REQ_PEAK: state_d = ST_SINIT;
						REQ_READ: state_d = ST_RADDR;
						default: begin
							cmd.res_op = RES_ZERO;
							state_d    = ST_DONE;
						end
					endcase
				end
			end
			ST_LOAD: begin
				cmd.load   = 1'b1;
				cmd.res_op = RES_LOAD;
				state_d    = ST_DONE;
			end
			ST_SINIT: begin
				cmd.srch_init = 1'b1;
				state_d       = ST_SCHK;
			end
			ST_SCHK: begin
				if (sts.lo_lt_hi) begin
					cmd.srch_issue = 1'b1;
					state_d        = ST_SCMP;
				end else begin
					cmd.scan_init = 1'b1;
					state_d       = ST_CHK;
				end
			end
			ST_SCMP: begin
				cmd.srch_cmp = 1'b1;
				state_d      = ST_SCHK;
			end
			ST_CHK: begin
				if (sts.idx_lt_cnt) begin
					cmd.scan_issue = 1'b1;
					state_d        = ST_EVAL;
				end else begin
					cmd.res_op = RES_PEAK;
					state_d    = ST_DONE;
				end
			end
			ST_EVAL: begin
				// Past the upper edge of the window: stop without touching the entry
				if (sts.scan_stop) begin
					cmd.res_op = RES_PEAK;
					state_d    = ST_DONE;
				end else begin
					cmd.scan_eval = 1'b1;
					state_d       = ST_CHK;
				end
			end
			ST_RADDR: begin
				if (sts.rd_in_range) begin
					cmd.rd_issue = 1'b1;
					state_d      = ST_RDATA;
				end else begin
					cmd.res_op = RES_RD_BAD;
					state_d    = ST_DONE;
				end
			end
			ST_RDATA: begin
				cmd.res_op = RES_RD_OK;
				state_d    = ST_DONE;
			end
			ST_DONE: begin
				// Hold until the output register frees up
				if (can_push) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

`include "fragment_peak_matcher_macros.svh"

	`FPM_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, accept, in_stall)
	`FPM_ASSERT_NEXT(a_push_shows_beat, clk, arst_n, cmd.out_load, out_valid)
	`FPM_ASSERT_NEXT(a_push_to_idle, clk, arst_n, cmd.out_load, state_q == ST_IDLE)

endmodule
`default_nettype wire

/* rtl/core/fragment_peak_matcher.sv */
// Peak: a bisection of at most ceil(log2(loaded+1)) steps, then a scan from the entry it
// finds, which stops past the window; one memory read per step sets the pace.
// Throughput: one item at a time; the next beat is taken once the result is in the
// output register, even while that result is still stalled. Reset (arst_n low): table
// empty, no result pending, tolerance 1311.
`default_nettype none
module fragment_peak_matcher
	import fpm_pkg::*;
#(
	parameter int unsigned TABLE_DEPTH = DEPTH_DEFAULT,
	parameter int unsigned FRAC_BITS   = FRAC_DEFAULT,
	parameter int unsigned RANK_BITS   = RANK_DEFAULT
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_stall,
	input  wire fpm_in_t          in_data,
	output logic                  out_valid,
	input  wire logic             out_stall,
	output fpm_out_t              out_data,
	input  wire logic             cfg_we,
	input  wire logic [TOL_W-1:0] cfg_wdata
);

	fpm_cmd_t cmd;
	fpm_sts_t sts;

	fpm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.req_type  (in_data.req_type),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	fpm_datapath #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.FRAC_BITS   (FRAC_BITS),
		.RANK_BITS   (RANK_BITS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd),
		.sts       (sts),
		.out_data  (out_data)
	);

endmodule
`default_nettype wire

/* sim/tb_fragment_peak_matcher.sv */
`timescale 1ns / 100ps
module tb_fragment_peak_matcher;
	import fpm_pkg::*;

	localparam int unsigned TABLE_DEPTH = DEPTH_DEFAULT;
	localparam longint unsigned HALF_MZ = 64'd1 << (FRAC_DEFAULT - 1);
	localparam logic [1:0] REQ_NONE = 2'd3;
	localparam int unsigned QUIET_LIMIT = 20000;
	localparam int N_DIR = 24;
	localparam int PHASE_ITEMS [6] = '{110, 110, 110, 110, 1250, 110};

	typedef struct {
		fpm_in_t  req;
		bit       fixed;
		fpm_out_t want;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	fpm_in_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	fpm_out_t out_data;
	logic cfg_we = 1'b0;
	logic [TOL_W-1:0] cfg_wdata = '0;

	// mirrored block state
	bit [MZ_W-1:0] frag_mz_mem [TABLE_DEPTH];
	bit [MZ_W-1:0] best_mz_mem [TABLE_DEPTH];
	bit [PRANK_W-1:0] best_rank_mem [TABLE_DEPTH];
	bit hit_mark [TABLE_DEPTH];
	int unsigned entries_loaded = 0;
	logic [TOL_W-1:0] tol_model = TOL_RESET;

	fpm_out_t pending_results [$];
	dir_row_t dir_rows [N_DIR];
	int unsigned items_sent = 0;
	int unsigned err_count = 0;
	int unsigned quiet_cycles = 0;
	int tx_idle_pct = 14;
	int rx_idle_pct = 82;
	int unsigned rx_hold_request = 0;
	int unsigned rx_hold_left = 0;

	fragment_peak_matcher dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic fpm_in_t req_of(logic [1:0] t, logic s, logic [MZ_W-1:0] mz,
			logic [PRANK_W-1:0] rk, logic [IDX_W-1:0] ix);
		fpm_in_t r;
		r.req_type = t;
		r.start_new = s;
		r.value_mz = mz;
		r.peak_rank = rk;
		r.entry_index = ix;
		return r;
	endfunction

	function automatic fpm_out_t res_of(logic [1:0] st, logic [MCNT_W-1:0] cnt, logic v,
			logic [MZ_W-1:0] fmz, logic [MZ_W-1:0] pmz, logic [PRANK_W-1:0] rk);
		fpm_out_t r;
		r.status = st;
		r.match_count = cnt;
		r.entry_valid = v;
		r.entry_fragment_mz = fmz;
		r.entry_peak_mz = pmz;
		r.entry_rank = rk;
		return r;
	endfunction

	// Response to one request; updates the mirrored fragment list and best peaks.
	function automatic fpm_out_t matcher_response(input fpm_in_t req);
		fpm_out_t res;
		longint unsigned mz, thr, f, gap, tol;
		int unsigned lo, hi, mid;
		res = '0;
		case (req.req_type)
			REQ_LOAD: begin
				if (req.start_new) begin
					entries_loaded = 0;
					foreach (hit_mark[i]) hit_mark[i] = 1'b0;
				end
				if (entries_loaded >= TABLE_DEPTH) begin
					res.status = STS_FULL;
				end else begin
					frag_mz_mem[entries_loaded] = req.value_mz;
					hit_mark[entries_loaded] = 1'b0;
					entries_loaded++;
				end
			end
			REQ_PEAK: begin
				mz = req.value_mz;
				tol = tol_model;
				thr = (mz >= HALF_MZ) ? mz - HALF_MZ : 0;
				lo = 0;
				hi = entries_loaded;
				// lower bound, whatever the order of the list
				while (lo < hi) begin
					mid = lo + (hi - lo) / 2;
					if (frag_mz_mem[mid] < thr) lo = mid + 1;
					else hi = mid;
				end
				for (int unsigned i = lo; i < entries_loaded; i++) begin
					f = frag_mz_mem[i];
					gap = (f > mz) ? f - mz : mz - f;
					if (gap < tol) begin
						if (!hit_mark[i] || best_rank_mem[i] > req.peak_rank) begin
							hit_mark[i] = 1'b1;
							best_mz_mem[i] = req.value_mz;
							best_rank_mem[i] = req.peak_rank;
							res.match_count = res.match_count + MCNT_W'(1);
						end
					end else if (f > mz + tol) begin
						break;
					end
				end
			end
			REQ_READ: begin
				if (req.entry_index < entries_loaded) begin
					res.entry_fragment_mz = frag_mz_mem[req.entry_index];
					if (hit_mark[req.entry_index]) begin
						res.entry_valid = 1'b1;
						res.entry_peak_mz = best_mz_mem[req.entry_index];
						res.entry_rank = best_rank_mem[req.entry_index];
					end
				end else begin
					res.status = STS_NO_IDX;
				end
			end
			default: ;
		endcase
		return res;
	endfunction

	// Call at a falling edge; returns at the falling edge after the beat is taken.
	task automatic send_item(input fpm_in_t req, input bit fixed = 1'b0,
			input fpm_out_t want = '0);
		fpm_out_t model_res;
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= req;
		do @(posedge clk); while (in_stall !== 1'b0);
		model_res = matcher_response(req);
		if (fixed) model_res = want;
		pending_results = {pending_results, model_res};
		items_sent++;
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_tolerance(input logic [TOL_W-1:0] v);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		tol_model = v;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Load a non-decreasing fragment list, then a mix of requests, mostly peaks and reads aimed at it.
	task automatic run_session(input int n_frag, input int n_ops, input longint unsigned base,
			input int unsigned max_step);
		fpm_in_t r;
		longint unsigned acc;
		longint signed near;
		int unsigned j, sel, span;
		acc = base;
		span = 2 * tol_model + 1;
		r = '0;
		for (int k = 0; k < n_frag; k++) begin
			r.req_type = REQ_LOAD;
			r.start_new = (k == 0);
			r.value_mz = acc[31:0];
			r.peak_rank = PRANK_W'($urandom);
			r.entry_index = IDX_W'($urandom);
			send_item(r);
			// mix tight spacing (overlapping windows) with wide gaps
			if ($urandom_range(0, 9) < 4) acc += $urandom_range(0, span);
			else acc += $urandom_range(1, max_step);
			if (acc > 64'hFFFF_FFFF) acc = 64'hFFFF_FFFF;
		end
		for (int k = 0; k < n_ops; k++) begin
			r.start_new = 1'($urandom);
			r.peak_rank = PRANK_W'($urandom_range(0, 1) ? $urandom_range(0, 15) : $urandom);
			r.entry_index = IDX_W'($urandom);
			r.value_mz = $urandom;
			j = (entries_loaded > 0) ? $urandom_range(0, entries_loaded - 1) : 0;
			sel = $urandom_range(0, 99);
			if (sel < 60) begin
				r.req_type = REQ_PEAK;
				near = longint'(frag_mz_mem[j]) + longint'($urandom_range(0, span + 64))
					- longint'(tol_model) - 32;
				if (near >= 0 && near < 64'sd4294967296) r.value_mz = near[31:0];
				else r.value_mz = frag_mz_mem[j];
			end else if (sel < 75) begin
				r.req_type = REQ_READ;
				r.entry_index = j[IDX_W-1:0];
			end else if (sel < 85) begin
				r.req_type = REQ_READ;
			end else if (sel < 92) begin
				r.req_type = REQ_PEAK;
			end else if (sel < 96) begin
				r.req_type = REQ_NONE;
			end else begin
				r.req_type = REQ_LOAD;
				r.start_new = ($urandom_range(0, 7) == 0);
			end
			send_item(r);
		end
	endtask

	initial begin
		fpm_in_t r;
		fpm_out_t none_out;
		int unsigned tol_plan [6];
		int unsigned phase_start;
		none_out = '0;
		dir_rows = '{
			'{req_of(REQ_READ, 1'b0, 32'd0, 16'd0, 10'd0), 1'b1,
				res_of(STS_NO_IDX, '0, 1'b0, '0, '0, '0)},
			'{req_of(REQ_PEAK, 1'b0, 32'h0001_0000, 16'd5, 10'd0), 1'b1, none_out},
			'{req_of(REQ_NONE, 1'b1, '1, '1, '1), 1'b1, none_out},
			'{req_of(REQ_LOAD, 1'b1, 32'h0000_0000, 16'd0, 10'd0), 1'b1, none_out},
			'{req_of(REQ_LOAD, 1'b0, 32'h0000_0400, 16'd0, 10'd0), 1'b1, none_out},
			'{req_of(REQ_LOAD, 1'b0, 32'h0001_0000, 16'd0, 10'd0), 1'b1, none_out},
			'{req_of(REQ_LOAD, 1'b0, 32'hFFFF_FFFF, 16'd0, 10'd0), 1'b1, none_out},
			// peak below one half: search starts at entry zero
			'{req_of(REQ_PEAK, 1'b0, 32'h0000_0100, 16'hFFFF, 10'd0), 1'b0, none_out},
			'{req_of(REQ_PEAK, 1'b0, 32'h0000_0100, 16'hFFFF, 10'd0), 1'b0, none_out},
			'{req_of(REQ_PEAK, 1'b0, 32'h0000_0200, 16'd0, 10'd0), 1'b0, none_out},
			'{req_of(REQ_READ, 1'b0, 32'd0, 16'd0, 10'd0), 1'b0, none_out},
			'{req_of(REQ_READ, 1'b0, 32'd0, 16'd0, 10'd2), 1'b1,
				res_of(STS_OK, '0, 1'b0, 32'h0001_0000, '0, '0)},
			'{req_of(REQ_PEAK, 1'b0, 32'hFFFF_FFFF, 16'h8000, 10'd0), 1'b0, none_out},
			'{req_of(REQ_READ, 1'b0, 32'd0, 16'd0, 10'd3), 1'b0, none_out},
			// distance equal to tolerance, then one below
			'{req_of(REQ_PEAK, 1'b0, 32'h0001_051F, 16'd2, 10'd0), 1'b0, none_out},
			'{req_of(REQ_PEAK, 1'b0, 32'h0001_051E, 16'd3, 10'd0), 1'b0, none_out},
			'{req_of(REQ_READ, 1'b0, 32'd0, 16'd0, 10'd4), 1'b1,
				res_of(STS_NO_IDX, '0, 1'b0, '0, '0, '0)},
			'{req_of(REQ_READ, 1'b0, 32'd0, 16'd0, 10'd1023), 1'b1,
				res_of(STS_NO_IDX, '0, 1'b0, '0, '0, '0)},
			'{req_of(REQ_LOAD, 1'b1, 32'h0005_0000, 16'd0, 10'd0), 1'b1, none_out},
			'{req_of(REQ_READ, 1'b0, 32'd0, 16'd0, 10'd0), 1'b1,
				res_of(STS_OK, '0, 1'b0, 32'h0005_0000, '0, '0)},
			// list out of ascending order
			'{req_of(REQ_LOAD, 1'b0, 32'h0003_0000, 16'd0, 10'd0), 1'b1, none_out},
			'{req_of(REQ_LOAD, 1'b0, 32'h0004_0000, 16'd0, 10'd0), 1'b1, none_out},
			'{req_of(REQ_PEAK, 1'b0, 32'h0003_0000, 16'd7, 10'd0), 1'b0, none_out},
			'{req_of(REQ_READ, 1'b0, 32'd0, 16'd0, 10'd1), 1'b0, none_out}
		};
		tol_plan = '{32768, 0, $urandom_range(1, 4000), 1, $urandom_range(600, 3000),
			$urandom_range(0, 32768)};
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		foreach (dir_rows[i]) send_item(dir_rows[i].req, dir_rows[i].fixed, dir_rows[i].want);
		for (int ph = 0; ph < 6; ph++) begin
			drain();
			tx_idle_pct = (ph < 2) ? 14 : (ph < 4) ? 82 : 0;
			rx_idle_pct = (ph < 2) ? 82 : (ph < 4) ? 14 : 0;
			write_tolerance(tol_plan[ph][TOL_W-1:0]);
			phase_start = items_sent;
			if (ph == 4) begin
				// hold the output side while loads keep coming, then fill past the end
				rx_hold_request = 400;
				run_session(1030, 80, longint'($urandom_range(0, 1 << 24)), 1 << 20);
			end
			while (items_sent - phase_start < PHASE_ITEMS[ph]) begin
				if ($urandom_range(0, 99) < 85) begin
					run_session($urandom_range(1, 24), $urandom_range(3, 20),
						($urandom_range(0, 7) == 0) ? 64'hFFFF_F000 : longint'($urandom),
						$urandom_range(0, 1) ? 32'd4096 : 32'd1048576);
				end else begin
					repeat ($urandom_range(4, 12)) begin
						r.req_type = 2'($urandom);
						r.start_new = 1'($urandom);
						r.value_mz = $urandom;
						r.peak_rank = PRANK_W'($urandom);
						r.entry_index = IDX_W'($urandom);
						send_item(r);
					end
				end
			end
		end
		drain();
		repeat (40) @(posedge clk);
		if (err_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

	always @(negedge clk) begin
		if (rx_hold_request != 0) begin
			rx_hold_left = rx_hold_request;
			rx_hold_request = 0;
		end
		if (rx_hold_left != 0) begin
			out_stall <= 1'b1;
			rx_hold_left--;
		end else begin
			out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
		end
	end

	task automatic note_error(input string msg);
		err_count++;
		if (err_count <= 10) $display("%s", msg);
	endtask

	always @(posedge clk) begin
		fpm_out_t want;
		if (arst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
			if (pending_results.size() == 0) begin
				note_error($sformatf("result beat with nothing pending: status %0d count %0d",
					out_data.status, out_data.match_count));
			end else begin
				want = pending_results.pop_front();
				if (out_data.status !== want.status ||
						out_data.match_count !== want.match_count ||
						out_data.entry_valid !== want.entry_valid ||
						out_data.entry_fragment_mz !== want.entry_fragment_mz ||
						out_data.entry_peak_mz !== want.entry_peak_mz ||
						out_data.entry_rank !== want.entry_rank) begin
					note_error($sformatf({"mismatch (exp/got): status %0d/%0d count %0d/%0d ",
						"valid %0d/%0d frag %h/%h peak %h/%h rank %h/%h"},
						want.status, out_data.status, want.match_count, out_data.match_count,
						want.entry_valid, out_data.entry_valid,
						want.entry_fragment_mz, out_data.entry_fragment_mz,
						want.entry_peak_mz, out_data.entry_peak_mz,
						want.entry_rank, out_data.entry_rank));
				end
			end
		end
	end

	// end the run if no beat moves on either side for too long
	always @(posedge clk) begin
		if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

endmodule
